[sv/kvlt_pkg.sv]
// Package for the key/value line tokenizer: result status codes,
// character constants and character class functions.
// No dependencies.
package kvlt_pkg;

  typedef enum logic [1:0] {
    ST_STRING = 2'd0,
    ST_NUMBER = 2'd1,
    ST_END    = 2'd2,
    ST_ERROR  = 2'd3
  } status_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_TAB) || (c == CH_SPACE) || (c == CH_CR);
  endfunction

  function automatic logic is_key_begin(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == CH_DOLLAR) || (c == CH_UNDER);
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_DOLLAR) ||
           (c == CH_DOT) || (c == CH_DASH);
  endfunction

  function automatic logic is_key_char(input logic [7:0] c);
    return is_key_begin(c) || is_num(c);
  endfunction

endpackage

[sv/key_value_line_tokenizer.sv]
// Key/value line tokenizer: one character per cycle while not stalled, one record per pair, error or end of stream.
// Output: a record is registered and shows in the cycle after the character that ends it.
// Throughput: one character per clock, stalled only while a record waits unread.
// Reset (rst_ni, async, active low): tokenizer between pairs at position zero,
// output register empty.
// Depends on kvlt_pkg.
module key_value_line_tokenizer
  import kvlt_pkg::*;
#(
  parameter int MAX_SOURCE_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_char_i,
  // record channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] key_offset_o,
  output logic [15:0] key_length_o,
  output logic [15:0] value_offset_o,
  output logic [15:0] value_length_o,
  output logic        end_of_input_o
);

  // Positions are capped at 64K since the offset fields are 16 bits wide.
  localparam int Limit = (MAX_SOURCE_BYTES < 65536) ? MAX_SOURCE_BYTES : 65536;
  localparam int PosW  = $clog2(Limit + 1);
  localparam logic [PosW-1:0] LimitPos = PosW'(Limit);

  // Tokenizer phases
  localparam logic [2:0] PH_BETWEEN  = 3'd0;
  localparam logic [2:0] PH_KEY      = 3'd1;
  localparam logic [2:0] PH_PRECOLON = 3'd2;
  localparam logic [2:0] PH_PREVALUE = 3'd3;
  localparam logic [2:0] PH_QUOTED   = 3'd4;
  localparam logic [2:0] PH_NUMBER   = 3'd5;
  localparam logic [2:0] PH_LINE     = 3'd6;
  localparam logic [2:0] PH_DISCARD  = 3'd7;

  logic [2:0]      phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] key_start_q, key_start_d;
  logic [PosW-1:0] key_len_q, key_len_d;
  logic [PosW-1:0] value_start_q, value_start_d;
  logic            quote_q, quote_d;   // 1: single quote, 0: double quote

  logic            in_acc;
  logic            emit;
  status_e         st;
  logic [PosW-1:0] ko, kl, vo, vl;
  logic            eoi;
  logic [PosW-1:0] p;
  logic [7:0]      c;

  logic            out_valid_q, out_valid_d;
  status_e         status_q;
  logic [15:0]     key_offset_q, key_length_q, value_offset_q, value_length_q;
  logic            eoi_q;

  // A character is taken unless a finished record sits unread at the output.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign c = in_char_i;
  assign p = pos_q;

  // One step of the tokenizer for the character at the input.
  always_comb begin
    phase_d       = phase_q;
    pos_d         = pos_q;
    key_start_d   = key_start_q;
    key_len_d     = key_len_q;
    value_start_d = value_start_q;
    quote_d       = quote_q;
    emit          = 1'b0;
    st            = ST_END;
    ko            = '0;
    kl            = '0;
    vo            = '0;
    vl            = '0;
    eoi           = 1'b0;

    if (phase_q == PH_DISCARD) begin
      // Drop everything up to the zero byte, which closes the stream.
      if (c == CH_NUL) begin
        emit    = 1'b1;
        st      = ST_END;
        eoi     = 1'b1;
        phase_d = PH_BETWEEN;
        pos_d   = '0;
      end
    end else if (pos_q >= LimitPos) begin
      // Overflow: any byte past the position limit is an error.
      emit = 1'b1;
      st   = ST_ERROR;
      eoi  = (c == CH_NUL);
      if (c == CH_NUL) begin
        phase_d = PH_BETWEEN;
        pos_d   = '0;
      end else begin
        phase_d = PH_DISCARD;
      end
    end else begin
      pos_d = pos_q + PosW'(1);
      unique case (phase_q) inside
        PH_BETWEEN: begin
          if (is_space(c)) begin
            // skip
          end else if (c == CH_NUL) begin
            emit    = 1'b1;
            st      = ST_END;
            eoi     = 1'b1;
            phase_d = PH_BETWEEN;
            pos_d   = '0;
          end else if (is_key_begin(c)) begin
            key_start_d = p;
            phase_d     = PH_KEY;
          end else begin
            emit    = 1'b1;
            st      = ST_ERROR;
            phase_d = PH_DISCARD;
          end
        end
        PH_KEY, PH_PRECOLON: begin
          if (phase_q == PH_KEY && c != CH_NUL && is_key_char(c)) begin
            // key goes on
          end else begin
            if (phase_q == PH_KEY) key_len_d = p - key_start_q;
            if (is_space(c)) begin
              phase_d = PH_PRECOLON;
            end else if (c == CH_COLON) begin
              phase_d = PH_PREVALUE;
            end else begin
              emit = 1'b1;
              st   = ST_ERROR;
              eoi  = (c == CH_NUL);
              if (c == CH_NUL) begin
                phase_d = PH_BETWEEN;
                pos_d   = '0;
              end else begin
                phase_d = PH_DISCARD;
              end
            end
          end
        end
        PH_PREVALUE: begin
          if (is_space(c)) begin
            // skip
          end else if (c == CH_NUL) begin
            emit    = 1'b1;
            st      = ST_ERROR;
            eoi     = 1'b1;
            phase_d = PH_BETWEEN;
            pos_d   = '0;
          end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            quote_d       = (c == CH_SQUOTE);
            value_start_d = p + PosW'(1);
            phase_d       = PH_QUOTED;
          end else begin
            value_start_d = p;
            phase_d       = is_num(c) ? PH_NUMBER : PH_LINE;
          end
        end
        PH_QUOTED: begin
          if (c == CH_NUL) begin
            emit    = 1'b1;
            st      = ST_ERROR;
            eoi     = 1'b1;
            phase_d = PH_BETWEEN;
            pos_d   = '0;
          end else if ((quote_q && c == CH_SQUOTE) || (!quote_q && c == CH_DQUOTE)) begin
            emit    = 1'b1;
            st      = ST_STRING;
            ko      = key_start_q;
            kl      = key_len_q;
            vo      = value_start_q;
            vl      = p - value_start_q;
            phase_d = PH_BETWEEN;
          end
        end
        PH_NUMBER: begin
          if (is_num(c)) begin
            // number goes on
          end else if (c == CH_NUL || is_space(c) || is_key_begin(c)) begin
            emit = 1'b1;
            st   = ST_NUMBER;
            ko   = key_start_q;
            kl   = key_len_q;
            vo   = value_start_q;
            vl   = p - value_start_q;
            eoi  = (c == CH_NUL);
            phase_d = PH_BETWEEN;
            if (c == CH_NUL) begin
              pos_d = '0;
            end else if (is_key_begin(c)) begin
              // The terminating byte opens the next key right away.
              key_start_d = p;
              phase_d     = PH_KEY;
            end
          end else begin
            emit    = 1'b1;
            st      = ST_ERROR;
            phase_d = PH_DISCARD;
          end
        end
        PH_LINE: begin
          if (c == CH_NUL || c == CH_LF || c == CH_CR) begin
            emit    = 1'b1;
            st      = ST_STRING;
            ko      = key_start_q;
            kl      = key_len_q;
            vo      = value_start_q;
            vl      = p - value_start_q;
            eoi     = (c == CH_NUL);
            phase_d = PH_BETWEEN;
            if (c == CH_NUL) pos_d = '0;
          end
        end
        default: begin
          phase_d = PH_BETWEEN;
        end
      endcase
    end
  end

  // Output word: load on a record, clear once taken.
  assign out_valid_d = (in_acc && emit) ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_BETWEEN;
      pos_q         <= '0;
      key_start_q   <= '0;
      key_len_q     <= '0;
      value_start_q <= '0;
      quote_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        phase_q       <= phase_d;
        pos_q         <= pos_d;
        key_start_q   <= key_start_d;
        key_len_q     <= key_len_d;
        value_start_q <= value_start_d;
        quote_q       <= quote_d;
      end
    end
  end

  // Payload holds while stalled; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      status_q       <= st;
      key_offset_q   <= 16'(ko);
      key_length_q   <= 16'(kl);
      value_offset_q <= 16'(vo);
      value_length_q <= 16'(vl);
      eoi_q          <= eoi;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign key_offset_o   = key_offset_q;
  assign key_length_o   = key_length_q;
  assign value_offset_o = value_offset_q;
  assign value_length_o = value_length_q;
  assign end_of_input_o = eoi_q;

  // Assertions
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no output word pending");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LimitPos)
    else $error("position ran past limit");

  a_end_marks_eoi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_END) |-> end_of_input_o)
    else $error("end record without end_of_input");

  a_nonpair_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_END || status_o == ST_ERROR)) |->
      (key_offset_o == 16'd0 && key_length_o == 16'd0 &&
       value_offset_o == 16'd0 && value_length_o == 16'd0))
    else $error("end or error record carries offsets");

  a_eoi_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && emit && eoi) |=> (pos_q == '0 && phase_q == PH_BETWEEN))
    else $error("zero byte did not restart the stream");

endmodule
